// ===== rtl/qfba_pkg.sv =====
package qfba_pkg;

  localparam int MAX_FAMILIES_DEF = 8;
  localparam int CAP_BITS_DEF     = 16;

  // fixed field widths of the ports
  localparam int CNT_W      = 4;
  localparam int SLOT_W     = 3;
  localparam int CAPS_W     = 16;
  localparam int CAPACITY_W = 8;
  localparam int FAM_W      = 3;
  localparam int CMP_W      = 6;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // search token control bits travelling down the row of cells
  typedef struct packed {
    logic valid;
    logic hit;
  } tok_ctl_t;

endpackage

// ===== rtl/qfba_cell.sv =====
module qfba_cell #(
  parameter int MAX_FAMILIES = qfba_pkg::MAX_FAMILIES_DEF,
  parameter int CAP_BITS     = qfba_pkg::CAP_BITS_DEF,
  parameter int INDEX        = 0,
  parameter int IDX_W        = (MAX_FAMILIES > 1) ? $clog2(MAX_FAMILIES) : 1,
  parameter int EXT_W        = $clog2(CAP_BITS + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            ld_we,
  input  logic [CAP_BITS-1:0]             ld_caps,
  input  logic [qfba_pkg::CAPACITY_W-1:0] ld_capacity,
  input  logic                            grant,
  input  logic [CAP_BITS-1:0]             req,
  input  logic [qfba_pkg::CNT_W-1:0]      cnt,
  input  qfba_pkg::tok_ctl_t              tok_i,
  input  logic [IDX_W-1:0]                bidx_i,
  input  logic [EXT_W-1:0]                bext_i,
  input  logic [CAP_BITS-1:0]             bcaps_i,
  input  logic [qfba_pkg::CAPACITY_W-1:0] bused_i,
  output qfba_pkg::tok_ctl_t              tok_o,
  output logic [IDX_W-1:0]                bidx_o,
  output logic [EXT_W-1:0]                bext_o,
  output logic [CAP_BITS-1:0]             bcaps_o,
  output logic [qfba_pkg::CAPACITY_W-1:0] bused_o
);

  logic [CAP_BITS-1:0]             caps_r;
  logic [qfba_pkg::CAPACITY_W-1:0] capacity_r;
  logic [qfba_pkg::CAPACITY_W-1:0] used_r, used_nxt;

  qfba_pkg::tok_ctl_t              tok_r, tok_nxt;
  logic [IDX_W-1:0]                bidx_r, bidx_nxt;
  logic [EXT_W-1:0]                bext_r, bext_nxt;
  logic [CAP_BITS-1:0]             bcaps_r, bcaps_nxt;
  logic [qfba_pkg::CAPACITY_W-1:0] bused_r, bused_nxt;

  logic [CAP_BITS-1:0] spare;
  logic [EXT_W-1:0]    extra;
  logic                active, fits, take;

  assign spare  = caps_r & ~req;
  assign active = qfba_pkg::CMP_W'(cnt) > qfba_pkg::CMP_W'(INDEX);
  assign fits   = tok_i.valid && active && ((caps_r & req) == req) && (used_r < capacity_r);
  assign take   = fits && (!tok_i.hit || (extra < bext_i));

  always_comb begin
    extra = '0;
    for (int b = 0; b < CAP_BITS; b++) begin
      extra = extra + EXT_W'(spare[b]);
    end
  end

  always_comb begin
    tok_nxt.valid = tok_i.valid;
    tok_nxt.hit   = tok_i.hit || take;
    bidx_nxt      = take ? IDX_W'(INDEX) : bidx_i;
    bext_nxt      = take ? extra : bext_i;
    bcaps_nxt     = take ? caps_r : bcaps_i;
    bused_nxt     = take ? used_r : bused_i;
  end

  always_comb begin
    used_nxt = used_r;
    if (ld_we) begin
      used_nxt = '0;
    end else if (grant) begin
      used_nxt = used_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      tok_r  <= '0;
    end else begin
      used_r <= used_nxt;
      tok_r  <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_we) begin
      caps_r     <= ld_caps;
      capacity_r <= ld_capacity;
    end
    bidx_r  <= bidx_nxt;
    bext_r  <= bext_nxt;
    bcaps_r <= bcaps_nxt;
    bused_r <= bused_nxt;
  end

  assign tok_o   = tok_r;
  assign bidx_o  = bidx_r;
  assign bext_o  = bext_r;
  assign bcaps_o = bcaps_r;
  assign bused_o = bused_r;

endmodule

// ===== rtl/queue_family_best_fit_allocator_core.sv =====
// Load request: the empty result passes through ST_DONE into the output register, and
// the next request is taken once it has gone there. Allocate request: a search token walks
// the row of family cells, one cell per cycle, and the result then passes through ST_DONE;
// the next request is taken once the result is in the output register, output permitting.
// Synchronous active-low reset clears the used counts, family_count and all control state;
// family masks and capacities hold no reset value until loaded.
module queue_family_best_fit_allocator_core #(
  parameter int MAX_FAMILIES = qfba_pkg::MAX_FAMILIES_DEF,
  parameter int CAP_BITS     = qfba_pkg::CAP_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_operation,
  input  logic [qfba_pkg::SLOT_W-1:0]     in_family_slot,
  input  logic [qfba_pkg::CAPS_W-1:0]     in_family_caps,
  input  logic [qfba_pkg::CAPACITY_W-1:0] in_family_capacity,
  input  logic [qfba_pkg::CAPS_W-1:0]     in_required_caps,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_found,
  output logic [qfba_pkg::FAM_W-1:0]      out_chosen_family,
  output logic [qfba_pkg::CAPACITY_W-1:0] out_unit_index,
  output logic [qfba_pkg::CAPS_W-1:0]     out_chosen_caps,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [qfba_pkg::CNT_W-1:0]      cfg_family_count
);

  localparam int IDX_W = (MAX_FAMILIES > 1) ? $clog2(MAX_FAMILIES) : 1;
  localparam int EXT_W = $clog2(CAP_BITS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                      state_r, state_nxt;
  logic                            start_r, start_nxt;
  logic [CAP_BITS-1:0]             req_r, req_nxt;
  logic [qfba_pkg::CNT_W-1:0]      family_count_r;

  logic                            res_found_r, res_found_nxt;
  logic [qfba_pkg::FAM_W-1:0]      res_family_r, res_family_nxt;
  logic [qfba_pkg::CAPACITY_W-1:0] res_unit_r, res_unit_nxt;
  logic [qfba_pkg::CAPS_W-1:0]     res_caps_r, res_caps_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic                            out_found_r;
  logic [qfba_pkg::FAM_W-1:0]      out_family_r;
  logic [qfba_pkg::CAPACITY_W-1:0] out_unit_r;
  logic [qfba_pkg::CAPS_W-1:0]     out_caps_r;
  logic                            out_load;

  logic                            in_fire, load_fire, scan_end;
  logic [CAP_BITS-1:0]             ld_caps;
  logic [MAX_FAMILIES-1:0]         ld_we, grant, tok_valid;

  qfba_pkg::tok_ctl_t              chain_tok   [MAX_FAMILIES+1];
  logic [IDX_W-1:0]                chain_idx   [MAX_FAMILIES+1];
  logic [EXT_W-1:0]                chain_ext   [MAX_FAMILIES+1];
  logic [CAP_BITS-1:0]             chain_caps  [MAX_FAMILIES+1];
  logic [qfba_pkg::CAPACITY_W-1:0] chain_used  [MAX_FAMILIES+1];

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign load_fire = in_fire && (in_operation == qfba_pkg::OP_LOAD);
  assign cfg_ready = 1'b1;
  assign ld_caps   = CAP_BITS'(in_family_caps);
  assign scan_end  = (state_r == ST_SCAN) && chain_tok[MAX_FAMILIES].valid;

  // inject the search token at the head of the row
  assign chain_tok[0].valid = start_r;
  assign chain_tok[0].hit   = 1'b0;
  assign chain_idx[0]       = '0;
  assign chain_ext[0]       = '0;
  assign chain_caps[0]      = '0;
  assign chain_used[0]      = '0;

  for (genvar i = 0; i < MAX_FAMILIES; i++) begin : g_cell
    assign ld_we[i] = load_fire &&
                      (qfba_pkg::CMP_W'(in_family_slot) == qfba_pkg::CMP_W'(i));
    assign grant[i] = scan_end && chain_tok[MAX_FAMILIES].hit &&
                      (chain_idx[MAX_FAMILIES] == IDX_W'(i));
    assign tok_valid[i] = chain_tok[i+1].valid;

    qfba_cell #(
      .MAX_FAMILIES (MAX_FAMILIES),
      .CAP_BITS     (CAP_BITS),
      .INDEX        (i),
      .IDX_W        (IDX_W),
      .EXT_W        (EXT_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ld_we       (ld_we[i]),
      .ld_caps     (ld_caps),
      .ld_capacity (in_family_capacity),
      .grant       (grant[i]),
      .req         (req_r),
      .cnt         (family_count_r),
      .tok_i       (chain_tok[i]),
      .bidx_i      (chain_idx[i]),
      .bext_i      (chain_ext[i]),
      .bcaps_i     (chain_caps[i]),
      .bused_i     (chain_used[i]),
      .tok_o       (chain_tok[i+1]),
      .bidx_o      (chain_idx[i+1]),
      .bext_o      (chain_ext[i+1]),
      .bcaps_o     (chain_caps[i+1]),
      .bused_o     (chain_used[i+1])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    start_nxt      = 1'b0;
    req_nxt        = req_r;
    res_found_nxt  = res_found_r;
    res_family_nxt = res_family_r;
    res_unit_nxt   = res_unit_r;
    res_caps_nxt   = res_caps_r;
    out_load       = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_operation == qfba_pkg::OP_LOAD) begin
            // acknowledge the load with an empty result
            res_found_nxt  = 1'b0;
            res_family_nxt = '0;
            res_unit_nxt   = '0;
            res_caps_nxt   = '0;
            state_nxt      = ST_DONE;
          end else begin
            req_nxt   = CAP_BITS'(in_required_caps);
            start_nxt = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          res_found_nxt = chain_tok[MAX_FAMILIES].hit;
          if (chain_tok[MAX_FAMILIES].hit) begin
            res_family_nxt = qfba_pkg::FAM_W'(chain_idx[MAX_FAMILIES]);
            res_unit_nxt   = chain_used[MAX_FAMILIES];
            res_caps_nxt   = qfba_pkg::CAPS_W'(chain_caps[MAX_FAMILIES]);
          end else begin
            res_family_nxt = '0;
            res_unit_nxt   = '0;
            res_caps_nxt   = '0;
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      start_r        <= 1'b0;
      out_valid_r    <= 1'b0;
      family_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        family_count_r <= cfg_family_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    res_found_r  <= res_found_nxt;
    res_family_r <= res_family_nxt;
    res_unit_r   <= res_unit_nxt;
    res_caps_r   <= res_caps_nxt;
    if (out_load) begin
      out_found_r  <= res_found_r;
      out_family_r <= res_family_r;
      out_unit_r   <= res_unit_r;
      out_caps_r   <= res_caps_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_chosen_family = out_family_r;
  assign out_unit_index    = out_unit_r;
  assign out_chosen_caps   = out_caps_r;

`ifndef SYNTHESIS
  a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_valid))
    else $error("more than one search token in the cell row");

  a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_SCAN) |-> (tok_valid == '0))
    else $error("search token present outside a scan");

  a_single_grant: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(grant))
    else $error("more than one family granted");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ST_IDLE))
    else $error("accepted request left no work in progress");
`endif

endmodule
